// ----- hw/rtl/svma_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the signed mesh volume accumulator.
// Used by svma_ctrl, svma_datapath and the top level; depends on nothing.
package svma_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int SUM_BITS_DEF   = 64;
	localparam int OUT_BITS       = 64;
	localparam int CFG_IDX_BITS   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_REF_X = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_REF_Y = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_REF_Z = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_CROSS,
		ST_DOT,
		ST_SUM,
		ST_ACC
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic accumulate;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
		logic out_free;
	} sts_t;

endpackage

// ----- hw/rtl/signed_mesh_volume_accumulator_core.sv -----
`timescale 1ns / 1ps
// Top level of the signed mesh volume accumulator.
// Instantiates svma_ctrl and svma_datapath; uses svma_pkg.
//
// Usage:
//  - Configuration: write ref_x/ref_y/ref_z (indexes 0..2) through cfg_valid,
//    cfg_index and cfg_data while the block is idle. cfg_ready is always high;
//    writes to other indexes are dropped. Reset sets the reference point to 0.
//  - Input: one triangle (vertices a, b, c) per beat on in_valid/in_ready.
//    last_triangle marks the final triangle of a mesh.
//  - Each triangle adds (B-A)x(C-A) . (A-R) to a running sum that saturates
//    to SUM_BITS signed; overflowed reports any clamp within the mesh.
//  - Output: one beat per mesh, on its last triangle: six_volume (sign
//    extended to 64 bits) and overflowed. The sum and flag then clear.
//  - Sequencing: the controller steps each triangle through difference, cross,
//    dot, sum and accumulate steps and accepts a new triangle only in idle;
//    the result is registered at the end of the last triangle's accumulate step.
//  - Stall: the result sits in an output register, so triangles keep flowing
//    while out_ready is low; only a further last triangle waits in the
//    accumulate step until the pending result is taken.
//  - Reset (arst_n low): sum, flag, output valid and sequencer clear at once.
module signed_mesh_volume_accumulator_core #(
	parameter int COORD_BITS = svma_pkg::COORD_BITS_DEF,
	parameter int SUM_BITS   = svma_pkg::SUM_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [svma_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [COORD_BITS-1:0]                cfg_data,
	// triangle input
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [COORD_BITS-1:0]         a_x,
	input  logic signed [COORD_BITS-1:0]         a_y,
	input  logic signed [COORD_BITS-1:0]         a_z,
	input  logic signed [COORD_BITS-1:0]         b_x,
	input  logic signed [COORD_BITS-1:0]         b_y,
	input  logic signed [COORD_BITS-1:0]         b_z,
	input  logic signed [COORD_BITS-1:0]         c_x,
	input  logic signed [COORD_BITS-1:0]         c_y,
	input  logic signed [COORD_BITS-1:0]         c_z,
	input  logic                                 last_triangle,
	// result output
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [svma_pkg::OUT_BITS-1:0] six_volume,
	output logic                                 overflowed
);

	svma_pkg::cmd_t cmd;
	svma_pkg::sts_t sts;

	// registers accept a write every cycle
	assign cfg_ready = 1'b1;

	svma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	svma_datapath #(
		.COORD_BITS (COORD_BITS),
		.SUM_BITS   (SUM_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.a_x           (a_x),
		.a_y           (a_y),
		.a_z           (a_z),
		.b_x           (b_x),
		.b_y           (b_y),
		.b_z           (b_z),
		.c_x           (c_x),
		.c_y           (c_y),
		.c_z           (c_z),
		.last_triangle (last_triangle),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.six_volume    (six_volume),
		.overflowed    (overflowed)
	);

endmodule

// ----- hw/rtl/svma_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the volume accumulator: walks one triangle through the
// datapath steps. Depends on svma_pkg (state_t, cmd_t, sts_t).
module svma_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  svma_pkg::sts_t    sts,
	output svma_pkg::cmd_t    cmd
);

	svma_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svma_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			svma_pkg::ST_IDLE: begin
				if (in_valid) state_d = svma_pkg::ST_DIFF;
			end
			svma_pkg::ST_DIFF:  state_d = svma_pkg::ST_CROSS;
			svma_pkg::ST_CROSS: state_d = svma_pkg::ST_DOT;
			svma_pkg::ST_DOT:   state_d = svma_pkg::ST_SUM;
			svma_pkg::ST_SUM:   state_d = svma_pkg::ST_ACC;
			svma_pkg::ST_ACC: begin
				// a last triangle waits for the output register to drain
				if (!sts.last || sts.out_free) state_d = svma_pkg::ST_IDLE;
			end
			default: state_d = svma_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == svma_pkg::ST_IDLE);
		cmd.capture    = (state_q == svma_pkg::ST_IDLE) && in_valid;
		cmd.accumulate = (state_q == svma_pkg::ST_ACC) && (!sts.last || sts.out_free);
	end

endmodule

// ----- hw/rtl/svma_datapath.sv -----
`timescale 1ns / 1ps
// Arithmetic for the volume accumulator: edge vectors, cross product, dot
// product, saturating sum and output register. Depends on svma_pkg.
module svma_datapath #(
	parameter int COORD_BITS = svma_pkg::COORD_BITS_DEF,
	parameter int SUM_BITS   = svma_pkg::SUM_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  svma_pkg::cmd_t                       cmd,
	output svma_pkg::sts_t                       sts,
	input  logic                                 cfg_we,
	input  logic [svma_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [COORD_BITS-1:0]                cfg_data,
	input  logic signed [COORD_BITS-1:0]         a_x,
	input  logic signed [COORD_BITS-1:0]         a_y,
	input  logic signed [COORD_BITS-1:0]         a_z,
	input  logic signed [COORD_BITS-1:0]         b_x,
	input  logic signed [COORD_BITS-1:0]         b_y,
	input  logic signed [COORD_BITS-1:0]         b_z,
	input  logic signed [COORD_BITS-1:0]         c_x,
	input  logic signed [COORD_BITS-1:0]         c_y,
	input  logic signed [COORD_BITS-1:0]         c_z,
	input  logic                                 last_triangle,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [svma_pkg::OUT_BITS-1:0] six_volume,
	output logic                                 overflowed
);

	localparam int DW = COORD_BITS + 1;   // coordinate difference
	localparam int PW = 2 * DW;           // one cross product partial
	localparam int NW = PW + 1;           // normal component
	localparam int QW = NW + DW;          // one dot product partial
	localparam int TW = QW + 2;           // per-triangle term
	localparam int AW = ((SUM_BITS > TW) ? SUM_BITS : TW) + 1;

	localparam logic signed [SUM_BITS-1:0] SUM_HI = {1'b0, {(SUM_BITS-1){1'b1}}};
	localparam logic signed [SUM_BITS-1:0] SUM_LO = {1'b1, {(SUM_BITS-1){1'b0}}};

	// reference point
	logic signed [COORD_BITS-1:0] ref_x_q, ref_y_q, ref_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_x_q <= '0;
			ref_y_q <= '0;
			ref_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				svma_pkg::REG_REF_X: ref_x_q <= cfg_data;
				svma_pkg::REG_REF_Y: ref_y_q <= cfg_data;
				svma_pkg::REG_REF_Z: ref_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured triangle
	logic signed [COORD_BITS-1:0] a_x_q, a_y_q, a_z_q, b_x_q, b_y_q, b_z_q;
	logic signed [COORD_BITS-1:0] c_x_q, c_y_q, c_z_q;
	logic                         last_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			a_x_q  <= a_x;
			a_y_q  <= a_y;
			a_z_q  <= a_z;
			b_x_q  <= b_x;
			b_y_q  <= b_y;
			b_z_q  <= b_z;
			c_x_q  <= c_x;
			c_y_q  <= c_y;
			c_z_q  <= c_z;
			last_q <= last_triangle;
		end
	end

	// step 1: U = B - A, V = C - A, D = A - R
	logic signed [DW-1:0] ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk) begin
		ux_s1 <= DW'(b_x_q) - DW'(a_x_q);
		uy_s1 <= DW'(b_y_q) - DW'(a_y_q);
		uz_s1 <= DW'(b_z_q) - DW'(a_z_q);
		vx_s1 <= DW'(c_x_q) - DW'(a_x_q);
		vy_s1 <= DW'(c_y_q) - DW'(a_y_q);
		vz_s1 <= DW'(c_z_q) - DW'(a_z_q);
		dx_s1 <= DW'(a_x_q) - DW'(ref_x_q);
		dy_s1 <= DW'(a_y_q) - DW'(ref_y_q);
		dz_s1 <= DW'(a_z_q) - DW'(ref_z_q);
	end

	// step 2: N = U x V
	logic signed [PW-1:0] p_uyvz, p_uzvy, p_uzvx, p_uxvz, p_uxvy, p_uyvx;
	logic signed [NW-1:0] nx_s2, ny_s2, nz_s2;

	assign p_uyvz = uy_s1 * vz_s1;
	assign p_uzvy = uz_s1 * vy_s1;
	assign p_uzvx = uz_s1 * vx_s1;
	assign p_uxvz = ux_s1 * vz_s1;
	assign p_uxvy = ux_s1 * vy_s1;
	assign p_uyvx = uy_s1 * vx_s1;

	always_ff @(posedge clk) begin
		nx_s2 <= NW'(p_uyvz) - NW'(p_uzvy);
		ny_s2 <= NW'(p_uzvx) - NW'(p_uxvz);
		nz_s2 <= NW'(p_uxvy) - NW'(p_uyvx);
	end

	// step 3: per-axis N * D
	logic signed [QW-1:0] q_x, q_y, q_z;
	logic signed [QW-1:0] qx_s3, qy_s3, qz_s3;

	assign q_x = nx_s2 * dx_s1;
	assign q_y = ny_s2 * dy_s1;
	assign q_z = nz_s2 * dz_s1;

	always_ff @(posedge clk) begin
		qx_s3 <= q_x;
		qy_s3 <= q_y;
		qz_s3 <= q_z;
	end

	// step 4: term = N . D
	logic signed [TW-1:0] term_s4;

	always_ff @(posedge clk) begin
		term_s4 <= TW'(qx_s3) + TW'(qy_s3) + TW'(qz_s3);
	end

	// step 5: saturating accumulate
	logic signed [SUM_BITS-1:0] running_sum_q;
	logic                       sat_q;
	logic signed [AW-1:0]       sum_wide;
	logic                       over_hi, over_lo;
	logic signed [SUM_BITS-1:0] sum_next;
	logic                       sat_next;

	always_comb begin
		sum_wide = AW'(running_sum_q) + AW'(term_s4);
		over_hi  = sum_wide > AW'(SUM_HI);
		over_lo  = sum_wide < AW'(SUM_LO);
		if (over_hi) begin
			sum_next = SUM_HI;
		end else if (over_lo) begin
			sum_next = SUM_LO;
		end else begin
			sum_next = $signed(sum_wide[SUM_BITS-1:0]);
		end
		sat_next = sat_q || over_hi || over_lo;
	end

	logic                                  out_valid_q;
	logic signed [svma_pkg::OUT_BITS-1:0]  six_volume_q;
	logic                                  overflowed_q;
	logic                                  out_free;
	logic                                  emit;

	assign out_free = !out_valid_q || out_ready;
	assign emit     = cmd.accumulate && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			sat_q         <= 1'b0;
		end else if (cmd.accumulate) begin
			if (last_q) begin
				running_sum_q <= '0;
				sat_q         <= 1'b0;
			end else begin
				running_sum_q <= sum_next;
				sat_q         <= sat_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			six_volume_q <= svma_pkg::OUT_BITS'(sum_next);
			overflowed_q <= sat_next;
		end
	end

	assign sts.last     = last_q;
	assign sts.out_free = out_free;
	assign out_valid    = out_valid_q;
	assign six_volume   = six_volume_q;
	assign overflowed   = overflowed_q;

	// a last triangle never overwrites an unread result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result register overwritten");

	// end of mesh leaves a clean sum and a pending result
	a_mesh_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (running_sum_q == '0) && !sat_q && out_valid_q)
		else $error("sum not cleared after last triangle");

	// the sum never moves without an accumulate command
	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.accumulate |=> $stable(running_sum_q) && $stable(sat_q))
		else $error("running sum changed while idle");

endmodule

// ----- bench/svma_volume_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the signed mesh volume accumulator: watches the config, triangle
// and result channels, predicts each mesh result and compares it field by field.
// Depends on svma_pkg for register indexes and widths.
module svma_volume_checker #(
	parameter int COORD_BITS = svma_pkg::COORD_BITS_DEF,
	parameter int SUM_BITS   = svma_pkg::SUM_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [svma_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [COORD_BITS-1:0]                cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic signed [COORD_BITS-1:0]         a_x,
	input  logic signed [COORD_BITS-1:0]         a_y,
	input  logic signed [COORD_BITS-1:0]         a_z,
	input  logic signed [COORD_BITS-1:0]         b_x,
	input  logic signed [COORD_BITS-1:0]         b_y,
	input  logic signed [COORD_BITS-1:0]         b_z,
	input  logic signed [COORD_BITS-1:0]         c_x,
	input  logic signed [COORD_BITS-1:0]         c_y,
	input  logic signed [COORD_BITS-1:0]         c_z,
	input  logic                                 last_triangle,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic signed [svma_pkg::OUT_BITS-1:0] six_volume,
	input  logic                                 overflowed,
	output int                                   mismatches,
	output int                                   pending
);

	typedef struct {
		longint x, y, z;
	} vec_t;

	typedef struct {
		logic signed [svma_pkg::OUT_BITS-1:0] six_volume;
		logic                                 overflowed;
	} volume_t;

	localparam longint SUM_HI = longint'((64'd1 << (SUM_BITS - 1)) - 64'd1);
	localparam longint SUM_LO = -SUM_HI - 1;

	vec_t    ref_pt;
	longint  mesh_sum;
	logic    mesh_clamped;
	volume_t volume_q[$];
	int      err_count = 0;

	function automatic vec_t vsub(vec_t p, vec_t q);
		vec_t r;
		r.x = p.x - q.x;
		r.y = p.y - q.y;
		r.z = p.z - q.z;
		return r;
	endfunction

	// (B-A) x (C-A) . (A-R): six times the signed tetrahedron volume
	function automatic longint tet_six_volume(vec_t a, vec_t b, vec_t c, vec_t r);
		vec_t   u, v, d;
		longint nx, ny, nz;
		u  = vsub(b, a);
		v  = vsub(c, a);
		d  = vsub(a, r);
		nx = u.y * v.z - u.z * v.y;
		ny = u.z * v.x - u.x * v.z;
		nz = u.x * v.y - u.y * v.x;
		return nx * d.x + ny * d.y + nz * d.z;
	endfunction

	function automatic void flag_error(string msg);
		if (err_count < 10)
			$display("%s", msg);
		err_count++;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		vec_t    a, b, c;
		longint  term;
		volume_t want;
		if (!arst_n) begin
			ref_pt       = '{0, 0, 0};
			mesh_sum     = 0;
			mesh_clamped = 1'b0;
			volume_q.delete();
			pending     <= 0;
		end else begin
			// result side first: a result never belongs to a triangle of this edge
			if (out_valid && out_ready) begin
				if (volume_q.size() == 0) begin
					flag_error($sformatf("result beat with nothing expected: six_volume %0d, overflowed %b",
						six_volume, overflowed));
				end else begin
					want = volume_q.pop_front();
					if (six_volume !== want.six_volume)
						flag_error($sformatf("six_volume: expected %0d, got %0d",
							want.six_volume, six_volume));
					if (overflowed !== want.overflowed)
						flag_error($sformatf("overflowed: expected %b, got %b",
							want.overflowed, overflowed));
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					svma_pkg::REG_REF_X: ref_pt.x = $signed(cfg_data);
					svma_pkg::REG_REF_Y: ref_pt.y = $signed(cfg_data);
					svma_pkg::REG_REF_Z: ref_pt.z = $signed(cfg_data);
					default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				a.x  = a_x;
				a.y  = a_y;
				a.z  = a_z;
				b.x  = b_x;
				b.y  = b_y;
				b.z  = b_z;
				c.x  = c_x;
				c.y  = c_y;
				c.z  = c_z;
				term = tet_six_volume(a, b, c, ref_pt);
				// saturating add; the flag sticks until the mesh closes
				if (term > 0 && mesh_sum > SUM_HI - term) begin
					mesh_sum     = SUM_HI;
					mesh_clamped = 1'b1;
				end else if (term < 0 && mesh_sum < SUM_LO - term) begin
					mesh_sum     = SUM_LO;
					mesh_clamped = 1'b1;
				end else begin
					mesh_sum += term;
				end
				if (last_triangle) begin
					want.six_volume = mesh_sum;
					want.overflowed = mesh_clamped;
					volume_q.push_back(want);
					mesh_sum     = 0;
					mesh_clamped = 1'b0;
				end
			end

			pending    <= volume_q.size();
			mismatches <= err_count;
		end
	end

endmodule

// ----- bench/tb_signed_mesh_volume_accumulator_core.sv -----
`timescale 1ns / 1ps
// Testbench top for signed_mesh_volume_accumulator_core: drives config and triangle
// beats, stalls the result side, and gives the verdict. Depends on svma_pkg, the
// RTL and svma_volume_checker (bench/svma_volume_checker.sv).
module tb_signed_mesh_volume_accumulator_core;

	localparam int COORD_BITS = svma_pkg::COORD_BITS_DEF;
	localparam int SUM_BITS   = svma_pkg::SUM_BITS_DEF;

	// index 3 is not a register; the block must drop writes to it
	localparam logic [svma_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

	// settle time before a config write: the result latency plus one triangle
	// that may still be in the sequencer, plus margin
	localparam int SETTLE_CYCLES  = 14;
	// longest quiet stretch in a good run is a sender gap plus a result stall
	// plus the block's own processing time; this is many times that
	localparam int WATCHDOG_LIMIT = 1000;
	// length of each one-sign run of near-maximal terms
	localparam int SAT_ITEMS      = 40;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct {
		coord_t x, y, z;
	} point_t;

	typedef struct {
		point_t a, b, c;
		logic   last;
	} triangle_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

	logic                                 clk;
	logic                                 arst_n        = 1'b0;
	logic                                 cfg_valid     = 1'b0;
	logic                                 cfg_ready;
	logic [svma_pkg::CFG_IDX_BITS-1:0]    cfg_index     = '0;
	logic [COORD_BITS-1:0]                cfg_data      = '0;
	logic                                 in_valid      = 1'b0;
	logic                                 in_ready;
	coord_t                               a_x           = '0;
	coord_t                               a_y           = '0;
	coord_t                               a_z           = '0;
	coord_t                               b_x           = '0;
	coord_t                               b_y           = '0;
	coord_t                               b_z           = '0;
	coord_t                               c_x           = '0;
	coord_t                               c_y           = '0;
	coord_t                               c_z           = '0;
	logic                                 last_triangle = 1'b0;
	logic                                 out_valid;
	logic                                 out_ready     = 1'b0;
	logic signed [svma_pkg::OUT_BITS-1:0] six_volume;
	logic                                 overflowed;

	int mismatches;
	int pending;
	int burst_left   = 0;
	int ready_hold   = 0;
	int quiet_cycles = 0;

	signed_mesh_volume_accumulator_core #(
		.COORD_BITS(COORD_BITS),
		.SUM_BITS  (SUM_BITS)
	) uut (
		.*
	);

	// scoreboard sits beside the block on the same wires
	svma_volume_checker #(
		.COORD_BITS(COORD_BITS),
		.SUM_BITS  (SUM_BITS)
	) vol_chk (
		.*
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side: alternates ready runs and stalls. Most ready runs are short so
	// stalls land on every phase of the sequencer; about one in four is long, which
	// gives stretches where the output never backs up.
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (out_ready) begin
			out_ready  <= 1'b0;
			ready_hold <= $urandom_range(0, 24);
		end else begin
			out_ready  <= 1'b1;
			ready_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(0, 10);
		end
	end

	// Watchdog: any accepted beat on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic point_t pt(coord_t x, coord_t y, coord_t z);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		return p;
	endfunction

	function automatic triangle_t make_tri(point_t a, point_t b, point_t c, logic last);
		triangle_t t;
		t.a    = a;
		t.b    = b;
		t.c    = c;
		t.last = last;
		return t;
	endfunction

	// mix of full-range, near-zero and corner values
	function automatic coord_t rand_coord();
		int s;
		s = $urandom_range(0, 16);
		case ($urandom_range(0, 5))
			0: return coord_t'(s - 8);
			1: begin
				case ($urandom_range(0, 3))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return coord_t'($urandom());
		endcase
	endfunction

	function automatic point_t rand_point();
		return pt(rand_coord(), rand_coord(), rand_coord());
	endfunction

	// random triangle; roughly one in four has a repeated vertex (zero area)
	function automatic triangle_t rand_tri(logic last);
		triangle_t t;
		t = make_tri(rand_point(), rand_point(), rand_point(), last);
		case ($urandom_range(0, 11))
			0: t.b = t.a;
			1: t.c = t.a;
			2: t.c = t.b;
			default: ;
		endcase
		return t;
	endfunction

	task automatic write_reg(input logic [svma_pkg::CFG_IDX_BITS-1:0] idx, input coord_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_ref(input coord_t rx, input coord_t ry, input coord_t rz);
		write_reg(svma_pkg::REG_REF_X, rx);
		write_reg(svma_pkg::REG_REF_Y, ry);
		write_reg(svma_pkg::REG_REF_Z, rz);
	endtask

	// One triangle beat. The sender runs in bursts; at a burst boundary it may drop
	// valid for a random gap. Valid stays high across beats inside a burst, so it is
	// never lowered and raised in the same step.
	task automatic send_tri(input triangle_t t);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid      <= 1'b1;
		a_x           <= t.a.x;
		a_y           <= t.a.y;
		a_z           <= t.a.z;
		b_x           <= t.b.x;
		b_y           <= t.b.y;
		b_z           <= t.b.z;
		c_x           <= t.c.x;
		c_y           <= t.c.y;
		c_z           <= t.c.z;
		last_triangle <= t.last;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid, wait for every expected result, then let the sequencer finish any
	// non-last triangle still in flight before the next config write.
	task automatic settle();
		in_valid  <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// closed tetrahedron, faces wound the same way: total is independent of R
	task automatic send_tetra(input point_t p0, input point_t p1, input point_t p2,
			input point_t p3);
		send_tri(make_tri(p0, p2, p1, 1'b0));
		send_tri(make_tri(p0, p1, p3, 1'b0));
		send_tri(make_tri(p0, p3, p2, 1'b0));
		send_tri(make_tri(p1, p2, p3, 1'b1));
	endtask

	// Run of near-maximal terms, all the same sign, to build a large sum. Expects
	// R at the all-minimum corner. One opposite triangle then pulls the sum back,
	// and a couple of random ones close the mesh.
	task automatic saturate(input logic downward);
		point_t a, b, c;
		int     i;
		b = pt(COORD_MIN, COORD_MAX, COORD_MAX);
		c = pt(COORD_MAX, COORD_MIN, COORD_MAX);
		a = pt(COORD_MAX, COORD_MAX, COORD_MAX);
		for (i = 0; i < SAT_ITEMS; i++) begin
			a = pt(COORD_MAX - coord_t'($urandom_range(0, 63)),
				COORD_MAX - coord_t'($urandom_range(0, 63)),
				COORD_MAX - coord_t'($urandom_range(0, 63)));
			send_tri(downward ? make_tri(a, c, b, 1'b0) : make_tri(a, b, c, 1'b0));
		end
		send_tri(downward ? make_tri(a, b, c, 1'b0) : make_tri(a, c, b, 1'b0));
		send_tri(rand_tri(1'b0));
		send_tri(rand_tri(1'b1));
	endtask

	// random meshes: closed tetrahedra, single-triangle meshes and open strips
	task automatic random_phase(input int quota);
		int sent;
		int n;
		int i;
		sent = 0;
		while (sent < quota) begin
			case ($urandom_range(0, 7))
				0: begin
					send_tetra(rand_point(), rand_point(), rand_point(), rand_point());
					sent += 4;
				end
				1: begin
					send_tri(rand_tri(1'b1));
					sent++;
				end
				default: begin
					n = $urandom_range(2, 12);
					for (i = 1; i <= n; i++)
						send_tri(rand_tri(i == n));
					sent += n;
				end
			endcase
		end
	endtask

	initial begin : stimulus
		int ph;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reference point left at its reset value (origin) ---
		// all vertices coincide: zero term
		send_tri(make_tri(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), 1'b1));
		// unit tetrahedron, both windings
		send_tri(make_tri(pt(1, 0, 0), pt(0, 1, 0), pt(0, 0, 1), 1'b1));
		send_tri(make_tri(pt(1, 0, 0), pt(0, 0, 1), pt(0, 1, 0), 1'b1));
		// corner coordinates, positive and negative volume
		send_tri(make_tri(pt(COORD_MAX, COORD_MAX, COORD_MAX),
			pt(COORD_MIN, COORD_MAX, COORD_MAX),
			pt(COORD_MAX, COORD_MIN, COORD_MAX), 1'b1));
		send_tri(make_tri(pt(COORD_MIN, COORD_MIN, COORD_MIN),
			pt(COORD_MAX, COORD_MIN, COORD_MIN),
			pt(COORD_MIN, COORD_MAX, COORD_MIN), 1'b1));
		// collinear vertices: zero area
		send_tri(make_tri(pt(-COORD_MAX, -COORD_MAX, -COORD_MAX), pt(0, 0, 0),
			pt(COORD_MAX, COORD_MAX, COORD_MAX), 1'b1));
		// repeated vertex inside a mesh, then a full-size closed tetrahedron
		send_tri(make_tri(pt(5, -7, 9), pt(5, -7, 9), pt(-3, 2, 1), 1'b0));
		send_tetra(pt(COORD_MIN, COORD_MIN, COORD_MIN), pt(COORD_MAX, COORD_MIN, COORD_MIN),
			pt(COORD_MIN, COORD_MAX, COORD_MIN), pt(COORD_MIN, COORD_MIN, COORD_MAX));
		// open mesh of several triangles
		send_tri(make_tri(pt(100, 200, 300), pt(-400, 50, 7), pt(9, -9, 1000), 1'b0));
		send_tri(make_tri(pt(-1, -1, -1), pt(2, 3, 4), pt(-5, 6, -7), 1'b0));
		send_tri(make_tri(pt(COORD_MAX, 0, COORD_MIN), pt(0, COORD_MAX, 0),
			pt(COORD_MIN, 0, COORD_MAX), 1'b0));
		send_tri(make_tri(pt(12, 34, 56), pt(-78, 90, -12), pt(34, -56, 78), 1'b1));
		settle();

		// --- corner reference point; the spare index must not disturb it ---
		set_ref(COORD_MAX, COORD_MIN, COORD_MAX);
		write_reg(REG_SPARE, rand_coord());
		send_tri(make_tri(pt(COORD_MIN, COORD_MAX, COORD_MIN),
			pt(COORD_MAX, COORD_MAX, COORD_MIN),
			pt(COORD_MIN, COORD_MIN, COORD_MIN), 1'b1));
		send_tri(make_tri(pt(COORD_MAX, COORD_MAX, COORD_MAX),
			pt(COORD_MIN, COORD_MIN, COORD_MAX),
			pt(COORD_MAX, COORD_MIN, COORD_MIN), 1'b0));
		send_tri(make_tri(pt(0, 0, 0), pt(1, 1, 1), pt(-1, 2, -3), 1'b1));
		settle();

		// --- large sums of both signs ---
		set_ref(COORD_MIN, COORD_MIN, COORD_MIN);
		saturate(1'b0);
		saturate(1'b1);
		settle();

		// --- random meshes under several reference points ---
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_ref(COORD_MAX, COORD_MAX, COORD_MAX);
				1: set_ref(rand_coord(), rand_coord(), rand_coord());
				2: write_reg(svma_pkg::REG_REF_Y, rand_coord());
				3: set_ref(0, 0, 0);
				4: set_ref(COORD_MIN, COORD_MAX, COORD_MIN);
				default: set_ref(coord_t'($urandom()), coord_t'($urandom()),
					coord_t'($urandom()));
			endcase
			random_phase(180);
			settle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/svma_pkg.sv
hw/rtl/svma_ctrl.sv
hw/rtl/svma_datapath.sv
hw/rtl/signed_mesh_volume_accumulator_core.sv
bench/svma_volume_checker.sv
bench/tb_signed_mesh_volume_accumulator_core.sv
